>>> hdl/ack_retransmit_outbox_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the retransmission outbox
// Concurrent assertion wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef ACK_RETRANSMIT_OUTBOX_DEFINES_SVH
`define ACK_RETRANSMIT_OUTBOX_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside of reset.
`define ARO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next.
`define ARO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ARO_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/aro_pkg.sv
// ----------------------------------------------------------------------------
// Retransmission outbox package
// Shared command, configuration, slot and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aro_pkg;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd_kind;

    typedef enum logic [0:0] {
        REG_ACK_TIMEOUT = 1'b0,
        REG_MAX_RETRIES = 1'b1
    } t_reg_idx;

    typedef enum logic [0:0] {
        BK_IDLE = 1'b0,
        BK_SCAN = 1'b1
    } t_back_state;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  msg_id;
        logic [31:0] now_ms;
    } t_cmd;

    typedef struct packed {
        logic [15:0] ack_timeout_ms;
        logic [3:0]  max_retries;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  msg_id;
        logic [3:0]  retries;
        logic [31:0] last_sent;
    } t_slot_entry;

    typedef struct packed {
        logic       enqueue_ok;
        logic [2:0] enqueue_slot;
        logic       ack_hit;
        logic       send_valid;
        logic [2:0] send_slot;
        logic [7:0] send_msg_id;
        logic [3:0] dropped_count;
        logic [3:0] pending_count;
    } t_result;

    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd2000;
    localparam logic [3:0]  MAX_RETRIES_RESET = 4'd3;

    function automatic logic [3:0] sat15(input logic [7:0] value);
        logic [3:0] result;
        result = (value > 8'd15) ? 4'd15 : value[3:0];
        return result;
    endfunction

endpackage

`default_nettype wire

>>> hdl/aro_cfg.sv
// ----------------------------------------------------------------------------
// Retransmission outbox register file
// APB-style access to the ack timeout and retry limit registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aro_cfg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    output aro_pkg::t_cfg     o_cfg
);
    import aro_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_timeout_ms <= ACK_TIMEOUT_RESET;
            r_cfg.max_retries    <= MAX_RETRIES_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ACK_TIMEOUT: r_cfg.ack_timeout_ms <= pwdata[15:0];
                REG_MAX_RETRIES: r_cfg.max_retries    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ACK_TIMEOUT: prdata = {16'd0, r_cfg.ack_timeout_ms};
            REG_MAX_RETRIES: prdata = {28'd0, r_cfg.max_retries};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/aro_front.sv
// ----------------------------------------------------------------------------
// Retransmission outbox front end
// Accepts command transactions, decodes them and queues them for the scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aro_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [1:0]   i_command,
    input  wire logic [7:0]   i_msg_id,
    input  wire logic [31:0]  i_now_ms,
    output logic              o_cmd_valid,
    output aro_pkg::t_cmd     o_cmd,
    input  wire logic         i_cmd_pop
);
    import aro_pkg::*;

    t_cmd       r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    t_cmd       w_cmd;

    assign o_in_stall  = (r_count == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_queue[r_rd_ptr];

    always_comb begin
        w_cmd.kind   = t_cmd_kind'(i_command);
        w_cmd.msg_id = i_msg_id;
        w_cmd.now_ms = i_now_ms;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !i_cmd_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_push && i_cmd_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/aro_back.sv
// ----------------------------------------------------------------------------
// Retransmission outbox slot scanner
// Walks the slot table one slot per cycle and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ack_retransmit_outbox_defines.svh"

module aro_back #(
    parameter int SLOTS = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cmd_valid,
    input  wire aro_pkg::t_cmd i_cmd,
    output logic              o_cmd_pop,
    input  wire aro_pkg::t_cfg i_cfg,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output aro_pkg::t_result  o_res
);
    import aro_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    t_slot_entry r_mem [SLOTS];
    t_slot_entry r_rd;

    t_back_state r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [SLOTS-1:0] r_busy, n_busy;
    logic [CNT_W-1:0] r_pend, n_pend;
    logic [CNT_W-1:0] r_drop, n_drop;
    logic        r_out_valid, n_out_valid;
    t_result     r_res, n_res;

    logic [IDX_W-1:0] w_idx_inc;
    logic [IDX_W-1:0] w_raddr;
    logic        w_we;
    t_slot_entry w_wdata;
    logic        w_done;
    logic        w_last;
    logic        w_slot_busy;
    logic [31:0] w_age;

    assign w_idx_inc   = r_idx + 1'b1;
    assign w_last      = (r_idx == IDX_W'(SLOTS - 1));
    assign w_slot_busy = r_busy[r_idx];
    assign w_age       = r_cmd.now_ms - r_rd.last_sent;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_busy      = r_busy;
        n_pend      = r_pend;
        n_drop      = r_drop;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        o_cmd_pop   = 1'b0;
        w_raddr     = w_idx_inc;
        w_we        = 1'b0;
        w_wdata     = '0;
        w_done      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && (!r_out_valid || !i_out_stall)) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_drop    = '0;
                    n_res     = '0;
                    w_raddr   = '0;
                    n_state   = BK_SCAN;
                end
            end
            BK_SCAN: begin
                w_done = w_last;
                unique case (r_cmd.kind)
                    CMD_ENQUEUE: begin
                        if (!w_slot_busy) begin
                            n_busy[r_idx]      = 1'b1;
                            n_pend             = r_pend + 1'b1;
                            w_we               = 1'b1;
                            w_wdata.msg_id     = r_cmd.msg_id;
                            w_wdata.retries    = 4'd0;
                            w_wdata.last_sent  = 32'd0;
                            n_res.enqueue_ok   = 1'b1;
                            n_res.enqueue_slot = 3'(r_idx);
                            w_done             = 1'b1;
                        end
                    end
                    CMD_ACK: begin
                        if (w_slot_busy && (r_rd.msg_id == r_cmd.msg_id)) begin
                            n_busy[r_idx] = 1'b0;
                            n_pend        = r_pend - 1'b1;
                            n_res.ack_hit = 1'b1;
                            w_done        = 1'b1;
                        end
                    end
                    CMD_TICK: begin
                        if (w_slot_busy) begin
                            priority if (r_rd.retries >= i_cfg.max_retries) begin
                                n_busy[r_idx] = 1'b0;
                                n_pend        = r_pend - 1'b1;
                                n_drop        = r_drop + 1'b1;
                            end else if ((r_rd.retries == 4'd0) ||
                                         (w_age >= {16'd0, i_cfg.ack_timeout_ms})) begin
                                w_we              = 1'b1;
                                w_wdata.msg_id    = r_rd.msg_id;
                                w_wdata.retries   = r_rd.retries + 4'd1;
                                w_wdata.last_sent = r_cmd.now_ms;
                                n_res.send_valid  = 1'b1;
                                n_res.send_slot   = 3'(r_idx);
                                n_res.send_msg_id = r_rd.msg_id;
                                w_done            = 1'b1;
                            end else begin
                                w_we = 1'b0;
                            end
                        end
                    end
                    CMD_NOP: begin
                        w_done = 1'b1;
                    end
                    default: ;
                endcase

                if (w_done) begin
                    n_state             = BK_IDLE;
                    n_out_valid         = 1'b1;
                    n_res.dropped_count = sat15(8'(n_drop));
                    n_res.pending_count = sat15(8'(n_pend));
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_busy      <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_drop <= n_drop;
        r_res  <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    `ARO_ASSERT(a_pend_matches_busy, i_clk, i_rst_n, r_pend == $countones(r_busy), "pending count differs from busy slots")
    `ARO_ASSERT(a_scan_output_empty, i_clk, i_rst_n, (r_state == BK_SCAN) |-> !r_out_valid, "result held while a scan runs")
    `ARO_ASSERT(a_one_outcome, i_clk, i_rst_n, r_out_valid |-> $onehot0({r_res.enqueue_ok, r_res.ack_hit, r_res.send_valid}), "result reports more than one outcome")
    `ARO_ASSERT_NEXT(a_pend_step, i_clk, i_rst_n, 1'b1, (r_pend == $past(r_pend)) || (r_pend == $past(r_pend) + 1'b1) || (r_pend == $past(r_pend) - 1'b1), "pending count moved by more than one")

endmodule

`default_nettype wire

>>> hdl/ack_retransmit_outbox.sv
// ----------------------------------------------------------------------------
// Acknowledged-message retransmission outbox
// Slot table that tracks messages awaiting acknowledgement and schedules
// resends on timer ticks.
//
// Commands enter on the input channel (i_in_valid / o_in_stall) and each one
// produces exactly one result transaction on the output channel
// (o_out_valid / i_out_stall). A two-entry command queue sits in front of a
// scanner that visits one slot per cycle from slot 0 upward. A command is
// popped from the queue in the idle state, then the scanner visits slots
// until the command completes or the last slot is reached. Results wait in
// an output register while the receiver stalls, and up to two further
// commands are still taken into the queue. Reset empties the table and the
// queue and loads the ack timeout with 2000 and the retry limit with 3; the
// table is usable in the first cycle after reset. The user must write the
// two registers over the APB port only while no command is in flight; the
// block itself does not enforce this. Packet bytes are kept outside the
// block, indexed by the reported slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ack_retransmit_outbox #(
    parameter int SLOTS = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [1:0]   i_command,
    input  wire logic [7:0]   i_msg_id,
    input  wire logic [31:0]  i_now_ms,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic              o_enqueue_ok,
    output logic [2:0]        o_enqueue_slot,
    output logic              o_ack_hit,
    output logic              o_send_valid,
    output logic [2:0]        o_send_slot,
    output logic [7:0]        o_send_msg_id,
    output logic [3:0]        o_dropped_count,
    output logic [3:0]        o_pending_count,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);
    import aro_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_cmd_pop;
    t_result w_res;

    aro_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    aro_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_msg_id    (i_msg_id),
        .i_now_ms    (i_now_ms),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    aro_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_cfg       (w_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (w_res)
    );

    assign o_enqueue_ok    = w_res.enqueue_ok;
    assign o_enqueue_slot  = w_res.enqueue_slot;
    assign o_ack_hit       = w_res.ack_hit;
    assign o_send_valid    = w_res.send_valid;
    assign o_send_slot     = w_res.send_slot;
    assign o_send_msg_id   = w_res.send_msg_id;
    assign o_dropped_count = w_res.dropped_count;
    assign o_pending_count = w_res.pending_count;

endmodule

`default_nettype wire
